// ===== design/idtbl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idtbl_pkg
// Shared widths, status codes and operation codes of the identifier table.
// ----------------------------------------------------------------------------
package idtbl_pkg;

	localparam int unsigned ID_W     = 64;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned IDX_W    = 6;
	localparam int unsigned CNT_W    = 7;

	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [ID_W-1:0]     card_id_t;
	typedef logic [IDX_W-1:0]    slot_idx_t;
	typedef logic [CNT_W-1:0]    count_t;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_EXISTS    = 2'd2;
	localparam status_t ST_NO_SPACE  = 2'd3;

	localparam logic FUNC_CHECK = 1'b0;
	localparam logic FUNC_ADD   = 1'b1;

endpackage

// ===== design/idtbl_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idtbl_mem
// Identifier storage: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module idtbl_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  idtbl_pkg::card_id_t   wr_data,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output idtbl_pkg::card_id_t   rd_data
);
	import idtbl_pkg::*;

	card_id_t mem [DEPTH];
	card_id_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/idtbl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idtbl_ctrl
// Request sequencer: scans the filled slots, inserts new identifiers and
// holds the result word in an output register.
// ----------------------------------------------------------------------------
module idtbl_ctrl #(
	parameter int unsigned TABLE_SLOTS = 64,
	parameter int unsigned AW          = 6,
	parameter int unsigned CW          = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     func,
	input  idtbl_pkg::card_id_t      card_id,
	output logic                     out_valid,
	input  logic                     out_ready,
	output idtbl_pkg::status_t       status,
	output idtbl_pkg::slot_idx_t     slot_index,
	output idtbl_pkg::count_t        valid_count,
	output logic                     mem_rd_en,
	output logic [AW-1:0]            mem_rd_addr,
	input  idtbl_pkg::card_id_t      mem_rd_data,
	output logic                     mem_wr_en,
	output logic [AW-1:0]            mem_wr_addr,
	output idtbl_pkg::card_id_t      mem_wr_data
);
	import idtbl_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_RESULT = 2'd2;

	logic [1:0]    state_q;
	logic          func_q;
	card_id_t      key_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic          cmp_vld_s1;
	logic [AW-1:0] cmp_idx_s1;
	status_t       res_status_q;
	logic [AW-1:0] res_idx_q;
	logic          out_valid_q;
	status_t       out_status_q;
	slot_idx_t     out_idx_q;
	count_t        out_cnt_q;

	logic accept;
	logic issue;
	logic hit;
	logic miss_done;
	logic out_free;
	logic full;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (count_q >= CW'(TABLE_SLOTS));
	assign issue     = (state_q == S_SCAN) && (rd_idx_q < count_q);
	assign hit       = (state_q == S_SCAN) && cmp_vld_s1 && (mem_rd_data == key_q);
	assign miss_done = (state_q == S_SCAN) && !cmp_vld_s1 && (rd_idx_q == count_q);
	assign out_free  = !out_valid_q || out_ready;

	assign mem_rd_en   = issue;
	assign mem_rd_addr = rd_idx_q[AW-1:0];
	assign mem_wr_en   = miss_done && (func_q == FUNC_ADD);
	assign mem_wr_addr = count_q[AW-1:0];
	assign mem_wr_data = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_idx_q   <= '0;
						cmp_vld_s1 <= 1'b0;
						if (func == FUNC_ADD && full) begin
							state_q <= S_RESULT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					cmp_vld_s1 <= issue;
					if (issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (hit) begin
						state_q <= S_RESULT;
					end else if (miss_done) begin
						if (func_q == FUNC_ADD) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (state_q == S_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q       <= func;
			key_q        <= card_id;
			res_status_q <= ST_NO_SPACE;
			res_idx_q    <= '0;
		end
		cmp_idx_s1 <= rd_idx_q[AW-1:0];
		if (hit) begin
			res_status_q <= (func_q == FUNC_ADD) ? ST_EXISTS : ST_OK;
			res_idx_q    <= cmp_idx_s1;
		end else if (miss_done) begin
			if (func_q == FUNC_ADD) begin
				res_status_q <= ST_OK;
				res_idx_q    <= count_q[AW-1:0];
			end else begin
				res_status_q <= ST_NOT_FOUND;
				res_idx_q    <= '0;
			end
		end
		if (state_q == S_RESULT && out_free) begin
			out_status_q <= res_status_q;
			out_idx_q    <= IDX_W'(res_idx_q);
			out_cnt_q    <= CNT_W'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign slot_index  = out_idx_q;
	assign valid_count = out_cnt_q;

endmodule

// ===== design/id_table_lookup_insert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_table_lookup_insert
// Table of 64-bit card identifiers with check and add requests.
//
//   channel | direction | handshake          | word
//   in      | input     | in_valid/in_ready  | func, card_id
//   out     | output    | out_valid/out_ready| status, slot_index, valid_count
//
// A request's time is set by the scan through the identifier memory read
// port, which reads the filled slots one slot per cycle; a request that
// hits returns sooner.
// Slots fill from the bottom and are never freed, so a fill count marks the
// valid slots and reset needs no clearing pass.
// A waiting result sits in the output register while the next word is taken;
// the following result waits for it to drain.
// ----------------------------------------------------------------------------
module id_table_lookup_insert #(
	parameter int unsigned TABLE_SLOTS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  func,
	input  idtbl_pkg::card_id_t   card_id,
	output logic                  out_valid,
	input  logic                  out_ready,
	output idtbl_pkg::status_t    status,
	output idtbl_pkg::slot_idx_t  slot_index,
	output idtbl_pkg::count_t     valid_count
);
	import idtbl_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_SLOTS);
	localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);

	logic          mem_rd_en;
	logic [AW-1:0] mem_rd_addr;
	card_id_t      mem_rd_data;
	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	card_id_t      mem_wr_data;

	idtbl_mem #(
		.DEPTH(TABLE_SLOTS),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	idtbl_ctrl #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.AW         (AW),
		.CW         (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.card_id    (card_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot_index (slot_index),
		.valid_count(valid_count),
		.mem_rd_en  (mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data),
		.mem_wr_en  (mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in progress");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> !mem_rd_en)
		else $error("insert write overlaps a scan read");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> (32'(mem_wr_addr) < TABLE_SLOTS))
		else $error("insert write beyond the table");

	a_idx_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NOT_FOUND || status == ST_NO_SPACE)
		|-> (slot_index == '0))
		else $error("failed request reports a slot");

endmodule

// ===== dv/id_table_lookup_insert_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_table_lookup_insert_tb
// Self-checking bench for the card identifier table. A directed opening covers
// empty-table misses, extreme identifiers, duplicates and near misses, then
// random check and add words fill the table and keep hitting it once full.
// The sender idles in bursts and the receiver stalls on a rotating pattern,
// with two long holds that back the block up. Every word is predicted by a
// local copy of the table and each answer is compared field by field.
// ----------------------------------------------------------------------------
module id_table_lookup_insert_tb;
	import idtbl_pkg::*;

	localparam int SLOTS        = 64;
	localparam int RANDOM_WORDS = 1300;
	localparam int HOLD_CYCLES  = 600;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct {
		logic     op;
		card_id_t key;
	} table_word_t;

	typedef struct packed {
		status_t   status;
		slot_idx_t slot;
		count_t    count;
	} table_answer_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	logic      func = FUNC_CHECK;
	card_id_t  card_id = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	status_t   status;
	slot_idx_t slot_index;
	count_t    valid_count;

	table_word_t   table_words[$];
	table_answer_t table_answers[$];
	card_id_t      added_keys[$];

	logic     id_used [SLOTS];
	card_id_t id_store [SLOTS];
	int       id_fill;

	table_word_t   next_word;
	table_answer_t fresh_answer;
	table_answer_t due_answer;
	int            outcome_cnt [2][4];
	int            words_total;
	int            words_taken;
	int            answers_seen;
	int            mismatches;
	int            burst_left;
	int            gap_left;
	int            hold_left;
	logic [15:0]   stall_pat;
	logic [5:0]    pat_age;
	int            cycle_cnt;

	id_table_lookup_insert #(
		.TABLE_SLOTS(SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.card_id(card_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.slot_index(slot_index),
		.valid_count(valid_count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic table_answer_t predict_table_answer(input logic op, input card_id_t key);
		table_answer_t ans;
		int hit;
		int hole;
		hit = -1;
		hole = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (hit < 0 && id_used[i] && id_store[i] == key)
				hit = i;
			if (hole < 0 && !id_used[i])
				hole = i;
		end
		ans.slot = '0;
		if (op == FUNC_CHECK) begin
			if (hit >= 0) begin
				ans.status = ST_OK;
				ans.slot = slot_idx_t'(hit);
			end else
				ans.status = ST_NOT_FOUND;
		end else if (id_fill >= SLOTS)
			ans.status = ST_NO_SPACE;
		else if (hit >= 0) begin
			ans.status = ST_EXISTS;
			ans.slot = slot_idx_t'(hit);
		end else if (hole >= 0) begin
			id_used[hole] = 1'b1;
			id_store[hole] = key;
			id_fill++;
			ans.status = ST_OK;
			ans.slot = slot_idx_t'(hole);
		end else
			ans.status = ST_NO_SPACE;
		ans.count = count_t'(id_fill);
		return ans;
	endfunction

	// Sender: presents queued words in bursts separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= FUNC_CHECK;
			card_id <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				fresh_answer = predict_table_answer(func, card_id);
				table_answers.push_back(fresh_answer);
				outcome_cnt[func][fresh_answer.status]++;
				words_taken++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (table_words.size() != 0) begin
					next_word = table_words.pop_front();
					in_valid <= 1'b1;
					func <= next_word.op;
					card_id <= next_word.key;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
					end else
						burst_left <= burst_left - 1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Receiver: checks each answer and stalls on a rotating pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			stall_pat <= 16'hFFFF;
			pat_age <= '0;
		end else begin
			if (out_valid && out_ready) begin
				answers_seen++;
				if (table_answers.size() == 0) begin
					$error("answer with no request pending: status %0d slot %0d count %0d",
						status, slot_index, valid_count);
					mismatches++;
				end else begin
					due_answer = table_answers.pop_front();
					if (status !== due_answer.status) begin
						$error("status: expected %0d, got %0d", due_answer.status, status);
						mismatches++;
					end
					if (slot_index !== due_answer.slot) begin
						$error("slot_index: expected %0d, got %0d", due_answer.slot, slot_index);
						mismatches++;
					end
					if (valid_count !== due_answer.count) begin
						$error("valid_count: expected %0d, got %0d", due_answer.count,
							valid_count);
						mismatches++;
					end
				end
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (out_valid && out_ready && (answers_seen == 100 || answers_seen == 700)) begin
				out_ready <= 1'b0;
				hold_left <= HOLD_CYCLES;
			end else begin
				out_ready <= stall_pat[0];
				pat_age <= pat_age + 6'd1;
				if (pat_age == '0) begin
					case ($urandom_range(0, 3))
						0: stall_pat <= 16'hFFFF;
						1: stall_pat <= 16'($urandom);
						2: stall_pat <= 16'($urandom | $urandom);
						default: stall_pat <= 16'($urandom & $urandom);
					endcase
				end else
					stall_pat <= {stall_pat[0], stall_pat[15:1]};
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		table_word_t w;
		card_id_t    pick;
		int          roll;
		cycle_cnt = 0;
		words_taken = 0;
		answers_seen = 0;
		mismatches = 0;
		id_fill = 0;
		for (int i = 0; i < SLOTS; i++) begin
			id_used[i] = 1'b0;
			id_store[i] = '0;
		end
		for (int o = 0; o < 2; o++)
			for (int s = 0; s < 4; s++)
				outcome_cnt[o][s] = 0;

		// Empty-table misses, extreme identifiers, duplicates and near misses.
		table_words.push_back('{FUNC_CHECK, 64'h0});
		table_words.push_back('{FUNC_CHECK, '1});
		table_words.push_back('{FUNC_ADD, 64'h0});
		table_words.push_back('{FUNC_ADD, '1});
		table_words.push_back('{FUNC_ADD, 64'h0});
		table_words.push_back('{FUNC_ADD, '1});
		table_words.push_back('{FUNC_CHECK, 64'h0});
		table_words.push_back('{FUNC_CHECK, '1});
		table_words.push_back('{FUNC_CHECK, 64'h1});
		table_words.push_back('{FUNC_CHECK, 64'h7FFF_FFFF_FFFF_FFFF});
		table_words.push_back('{FUNC_ADD, 64'h8000_0000_0000_0000});
		table_words.push_back('{FUNC_ADD, 64'h5555_5555_5555_5555});
		table_words.push_back('{FUNC_ADD, 64'hAAAA_AAAA_AAAA_AAAA});
		table_words.push_back('{FUNC_CHECK, 64'hAAAA_AAAA_AAAA_AAAA});
		table_words.push_back('{FUNC_CHECK, 64'h5555_5555_5555_5555});
		table_words.push_back('{FUNC_CHECK, 64'hAAAA_AAAA_AAAA_AAAB});
		table_words.push_back('{FUNC_ADD, 64'h5555_5555_5555_5555});
		table_words.push_back('{FUNC_CHECK, 64'h8000_0000_0000_0000});
		added_keys.push_back(64'h0);
		added_keys.push_back('1);
		added_keys.push_back(64'h8000_0000_0000_0000);
		added_keys.push_back(64'h5555_5555_5555_5555);
		added_keys.push_back(64'hAAAA_AAAA_AAAA_AAAA);

		// Mostly hits and near misses on stored identifiers; fresh adds fill
		// the table about halfway through, after which adds are refused.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			roll = $urandom_range(0, 99);
			pick = added_keys[$urandom_range(0, added_keys.size() - 1)];
			if (roll < 10) begin
				w.op = FUNC_ADD;
				w.key = {$urandom, $urandom};
				added_keys.push_back(w.key);
			end else if (roll < 16) begin
				w.op = FUNC_ADD;
				w.key = pick;
			end else if (roll < 56) begin
				w.op = FUNC_CHECK;
				w.key = pick;
			end else if (roll < 72) begin
				w.op = FUNC_CHECK;
				w.key = pick ^ (64'h1 << $urandom_range(0, 63));
			end else begin
				w.op = FUNC_CHECK;
				w.key = {$urandom, $urandom};
			end
			table_words.push_back(w);
		end
		words_total = table_words.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (words_taken != words_total)
			@(posedge clk);
		while (answers_seen < words_taken)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);
		if (table_answers.size() != 0) begin
			$error("%0d answers never arrived", table_answers.size());
			mismatches++;
		end

		$display("Ran %0d words through a %0d-slot table, ending with %0d entries filled.",
			words_total, SLOTS, id_fill);
		$display("Checks: %0d hits, %0d misses. Adds: %0d stored, %0d duplicates, %0d refused.",
			outcome_cnt[FUNC_CHECK][ST_OK], outcome_cnt[FUNC_CHECK][ST_NOT_FOUND],
			outcome_cnt[FUNC_ADD][ST_OK], outcome_cnt[FUNC_ADD][ST_EXISTS],
			outcome_cnt[FUNC_ADD][ST_NO_SPACE]);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
